@@ src/ccal_pkg.sv @@
// Package for the clock calendar with alarm.
// Holds request and response payload types, action and key codes, and limits.
// No dependencies.
`default_nettype none

package ccal_pkg;

   // Action codes; the unused fourth code changes nothing but checks the alarm.
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_KEY  = 2'd1;
   localparam logic [1:0] ACT_LOAD = 2'd2;

   // Key codes.
   localparam logic [2:0] KEY_NONE  = 3'd0;
   localparam logic [2:0] KEY_UP    = 3'd1;
   localparam logic [2:0] KEY_LEFT  = 3'd2;
   localparam logic [2:0] KEY_DOWN  = 3'd3;
   localparam logic [2:0] KEY_RIGHT = 3'd4;
   localparam logic [2:0] KEY_OK    = 3'd5;
   localparam logic [2:0] KEY_BACK  = 3'd6;

   // Month numbers and limits.
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_APR = 4'd4;
   localparam logic [3:0]  MONTH_JUN = 4'd6;
   localparam logic [3:0]  MONTH_SEP = 4'd9;
   localparam logic [3:0]  MONTH_NOV = 4'd11;
   localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;
   localparam logic [13:0] YEAR_MAX = 14'd9999;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  key_code;
      logic [4:0]  load_hours;
      logic [5:0]  load_minutes;
      logic [5:0]  load_seconds;
      logic [4:0]  load_day;
      logic [3:0]  load_month;
      logic [13:0] load_year;
   } req_type;

   typedef struct packed {
      logic [4:0]  hours_now;
      logic [5:0]  minutes_now;
      logic [5:0]  seconds_now;
      logic [4:0]  day_now;
      logic [3:0]  month_now;
      logic [13:0] year_now;
      logic [4:0]  alarm_hours_now;
      logic [5:0]  alarm_minutes_now;
      logic        ringing;
      logic        day_rolled;
      logic        key_consumed;
   } rsp_type;

endpackage

`default_nettype wire

@@ src/clock_calendar_with_alarm.sv @@
// Top level of the clock calendar with alarm.
// Time, date and alarm state, single-pass update logic and the response register.
// Depends on ccal_pkg.
`default_nettype none

// Each accepted request (tick, key press or load) updates the clock, calendar
// and alarm state in the cycle it is accepted and yields exactly one response,
// which appears in the response register on the following cycle. A request is
// taken every cycle in which the response register is empty or being emptied,
// so the sustained rate is one request per clock; the single update pass between
// the request port and the response register sets this figure. The alarm enable
// register is written through csr_wr_en and csr_wr_data and has no read-back.
module clock_calendar_with_alarm
   import ccal_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data
);

   logic [5:0]  seconds_ff, seconds_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [4:0]  hours_ff, hours_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic [4:0]  alarm_hours_ff, alarm_hours_in;
   logic [5:0]  alarm_minutes_ff, alarm_minutes_in;
   logic        edit_minutes_ff, edit_minutes_in;
   logic        ringing_ff, ringing_in;
   logic        alarm_enable_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        rolled;
   logic        consumed;
   logic [6:0]  sec_inc, min_inc;
   logic [5:0]  hrs_inc;
   logic [5:0]  day_inc;
   logic [4:0]  month_inc;
   logic [4:0]  month_len;

   function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                input logic [13:0] year);
      logic [4:0] len;
      if (month == MONTH_FEB) begin
         len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         len = 5'd30;
      end else begin
         len = 5'd31;
      end
      return len;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Incremented values; seconds, minutes and hours stay below twice their modulus,
   // so one compare and subtract wraps them even for out-of-range counts; day and month wrap to one.
   assign sec_inc   = {1'b0, seconds_ff} + 7'd1;
   assign min_inc   = {1'b0, minutes_ff} + 7'd1;
   assign hrs_inc   = {1'b0, hours_ff} + 6'd1;
   assign day_inc   = {1'b0, day_ff} + 6'd1;
   assign month_inc = {1'b0, month_ff} + 5'd1;
   assign month_len = days_in_month(month_ff, year_ff);

   always_comb begin
      seconds_in       = seconds_ff;
      minutes_in       = minutes_ff;
      hours_in         = hours_ff;
      day_in           = day_ff;
      month_in         = month_ff;
      year_in          = year_ff;
      alarm_hours_in   = alarm_hours_ff;
      alarm_minutes_in = alarm_minutes_ff;
      edit_minutes_in  = edit_minutes_ff;
      ringing_in       = ringing_ff;
      rolled           = 1'b0;
      consumed         = 1'b0;

      if (req_data.action == ACT_TICK) begin
         seconds_in = (sec_inc >= 7'd60) ? 6'(sec_inc - 7'd60) : sec_inc[5:0];
         if (seconds_in == 6'd0) begin
            minutes_in = (min_inc >= 7'd60) ? 6'(min_inc - 7'd60) : min_inc[5:0];
            if (minutes_in == 6'd0) begin
               hours_in = (hrs_inc >= 6'd24) ? 5'(hrs_inc - 6'd24) : hrs_inc[4:0];
               if (hours_in == 5'd0) begin
                  rolled = 1'b1;
                  if (day_inc > {1'b0, month_len}) begin
                     day_in = 5'd1;
                     if (month_inc > MONTHS_PER_YEAR) begin
                        month_in = 4'd1;
                        year_in  = (year_ff >= YEAR_MAX) ? 14'd0 : year_ff + 14'd1;
                     end else begin
                        month_in = month_inc[3:0];
                     end
                  end else begin
                     day_in = day_inc[4:0];
                  end
               end
            end
         end
      end else if (req_data.action == ACT_LOAD) begin
         hours_in   = req_data.load_hours;
         minutes_in = req_data.load_minutes;
         seconds_in = req_data.load_seconds;
         day_in     = req_data.load_day;
         month_in   = req_data.load_month;
         year_in    = req_data.load_year;
      end

      // The match is checked on the updated time, before any key clears it.
      if (alarm_enable_ff && hours_in == alarm_hours_ff &&
          minutes_in == alarm_minutes_ff && seconds_in == 6'd0) begin
         ringing_in = 1'b1;
      end

      if (req_data.action == ACT_KEY && req_data.key_code != KEY_NONE) begin
         ringing_in = 1'b0;
         unique case (req_data.key_code)
            KEY_RIGHT: begin
               edit_minutes_in = 1'b1;
               consumed        = 1'b1;
            end
            KEY_LEFT: begin
               edit_minutes_in = 1'b0;
               consumed        = 1'b1;
            end
            KEY_UP: begin
               if (edit_minutes_ff) begin
                  alarm_minutes_in = (alarm_minutes_ff >= 6'd59) ? 6'd0
                                                                 : alarm_minutes_ff + 6'd1;
               end else begin
                  alarm_hours_in = (alarm_hours_ff >= 5'd23) ? 5'd0
                                                             : alarm_hours_ff + 5'd1;
               end
               consumed = 1'b1;
            end
            KEY_DOWN: begin
               if (edit_minutes_ff) begin
                  alarm_minutes_in = (alarm_minutes_ff == 6'd0) ? 6'd59
                                                                : alarm_minutes_ff - 6'd1;
               end else begin
                  alarm_hours_in = (alarm_hours_ff == 5'd0) ? 5'd23
                                                            : alarm_hours_ff - 5'd1;
               end
               consumed = 1'b1;
            end
            default: begin
               // Ok, back and the spare code only silence the alarm.
               consumed = 1'b0;
            end
         endcase
      end

      rsp_data_in.hours_now         = hours_in;
      rsp_data_in.minutes_now       = minutes_in;
      rsp_data_in.seconds_now       = seconds_in;
      rsp_data_in.day_now           = day_in;
      rsp_data_in.month_now         = month_in;
      rsp_data_in.year_now          = year_in;
      rsp_data_in.alarm_hours_now   = alarm_hours_in;
      rsp_data_in.alarm_minutes_now = alarm_minutes_in;
      rsp_data_in.ringing           = ringing_in;
      rsp_data_in.day_rolled        = rolled;
      rsp_data_in.key_consumed      = consumed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff       <= 6'd45;
         minutes_ff       <= 6'd59;
         hours_ff         <= 5'd17;
         day_ff           <= 5'd14;
         month_ff         <= 4'd12;
         year_ff          <= 14'd2019;
         alarm_hours_ff   <= 5'd18;
         alarm_minutes_ff <= 6'd0;
         edit_minutes_ff  <= 1'b0;
         ringing_ff       <= 1'b0;
         alarm_enable_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            alarm_enable_ff <= csr_wr_data;
         end
         if (accept) begin
            seconds_ff       <= seconds_in;
            minutes_ff       <= minutes_in;
            hours_ff         <= hours_in;
            day_ff           <= day_in;
            month_ff         <= month_in;
            year_ff          <= year_in;
            alarm_hours_ff   <= alarm_hours_in;
            alarm_minutes_ff <= alarm_minutes_in;
            edit_minutes_ff  <= edit_minutes_in;
            ringing_ff       <= ringing_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Every accepted request leaves a response waiting in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no response");

   // A midnight rollover always leaves the time at exactly midnight.
   a_rolled_at_midnight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.day_rolled) |->
         (rsp_data.hours_now == 5'd0 && rsp_data.minutes_now == 6'd0 &&
          rsp_data.seconds_now == 6'd0))
      else $error("day rollover reported away from midnight");

   // A consumed key silences the alarm in the same step.
   a_key_silences: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.key_consumed) |-> !rsp_data.ringing)
      else $error("alarm still ringing after a consumed key");

   // Alarm editing wraps, so the alarm time never leaves its range.
   a_alarm_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.alarm_hours_now <= 5'd23 &&
                     rsp_data.alarm_minutes_now <= 6'd59))
      else $error("alarm time out of range");

endmodule

`default_nettype wire
